>>> hdl/arq_pkg.sv
// Shared types and constants for the AND reachability query engine.
// No dependencies; every other file refers to this package by scoped names.
package arq_pkg;

  localparam int DEPTH = 4096;
  localparam int BITS = 20;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = CNT_W;
  localparam int K_W = (BITS > 1) ? $clog2(BITS) : 1;
  localparam int POS_W = 12;
  localparam int QDEPTH = 2;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_BAD = 2'd2
  } kind_t;

  typedef struct packed {
    logic req_type;
    logic [19:0] value;
    logic [POS_W-1:0] from_pos;
    logic [POS_W-1:0] to_pos;
  } req_t;

  typedef struct packed {
    logic reachable;
    logic bad_index;
  } rsp_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    kind_t kind;
    logic [BITS-1:0] value;
    logic [POS_W-1:0] s_pos;
    logic [POS_W-1:0] t_pos;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

  typedef logic [BITS-1:0][ENT_W-1:0] row_t;

endpackage

>>> hdl/and_reachability_query_engine.sv
// Top level of the AND reachability query engine: front, queue and back.
// Depends on arq_pkg, arq_front, arq_queue and arq_back.
//
//   channel   ports              handshake
//   request   start, busy, req   taken when start is high and busy is low
//   response  done, rsp          valid for the one cycle done is high
//
// An append occupies the back for a scan with at most one table row read per bit,
// then a drain and a write step. A query takes a read and an evaluate step, a
// bad-index query neither. The single-port reach table scan sets the append time.
// busy rises only when the two-entry queue is full; results cannot be held off.
// Reset (rst, synchronous) empties the queue and clears all positions.
module and_reachability_query_engine (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  arq_pkg::req_t req,
  output logic done,
  output arq_pkg::rsp_t rsp
);

  arq_pkg::qctl_t qctl;
  arq_pkg::entry_t push_entry;
  arq_pkg::entry_t head_entry;
  logic q_full;
  logic q_empty;

  arq_front u_front (
    .clk(clk), .rst(rst), .start(start), .req(req), .q_full(q_full),
    .busy(busy), .push(qctl.push), .entry(push_entry)
  );

  arq_queue u_queue (
    .clk(clk), .rst(rst), .ctl(qctl), .wr_entry(push_entry),
    .rd_entry(head_entry), .full(q_full), .empty(q_empty)
  );

  arq_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_entry(head_entry),
    .pop(qctl.pop), .done(done), .rsp(rsp)
  );

endmodule

>>> hdl/arq_queue.sv
// Two-entry queue of classified items between the front and the back.
// Depends on arq_pkg.
module arq_queue (
  input  logic clk,
  input  logic rst,
  input  arq_pkg::qctl_t ctl,
  input  arq_pkg::entry_t wr_entry,
  output arq_pkg::entry_t rd_entry,
  output logic full,
  output logic empty
);

  arq_pkg::entry_t slots [arq_pkg::QDEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'(arq_pkg::QDEPTH));
  assign empty = (count == 2'd0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (ctl.push) wr_ptr <= ~wr_ptr;
      if (ctl.pop) rd_ptr <= ~rd_ptr;
      case ({ctl.push, ctl.pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/arq_front.sv
// Front end: accepts items, checks query positions against the number of
// appends already taken, and drops appends past the table depth. Uses arq_pkg.
module arq_front (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  arq_pkg::req_t req,
  input  logic q_full,
  output logic busy,
  output logic push,
  output arq_pkg::entry_t entry
);

  // Counts appends taken, so it runs ahead of the back's own count.
  logic [arq_pkg::CNT_W-1:0] taken;
  logic accept;
  logic is_query;
  logic bad;
  logic full_tab;

  assign busy = q_full;
  assign accept = start && !busy;
  assign is_query = (req.req_type == arq_pkg::REQ_QUERY);
  assign full_tab = (taken == arq_pkg::CNT_W'(arq_pkg::DEPTH));
  assign bad = ({1'b0, req.from_pos} >= taken) || ({1'b0, req.to_pos} >= taken);
  assign push = accept && (is_query || !full_tab);

  always_comb begin
    entry.value = req.value[arq_pkg::BITS-1:0];
    if (req.from_pos < req.to_pos) begin
      entry.s_pos = req.from_pos;
      entry.t_pos = req.to_pos;
    end else begin
      entry.s_pos = req.to_pos;
      entry.t_pos = req.from_pos;
    end
    if (!is_query) entry.kind = arq_pkg::KIND_APPEND;
    else if (bad) entry.kind = arq_pkg::KIND_BAD;
    else entry.kind = arq_pkg::KIND_QUERY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (accept && !is_query && !full_tab) begin
      taken <= taken + 1'b1;
    end
  end

endmodule

>>> hdl/arq_back.sv
// Back end: holds the value store and the reach table, builds a table row for
// each append by scanning one bit per cycle, and answers queries. Uses arq_pkg.
module arq_back (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  arq_pkg::entry_t q_entry,
  output logic pop,
  output logic done,
  output arq_pkg::rsp_t rsp
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_QREAD = 6'b010000,
    ST_QEVAL = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [arq_pkg::BITS-1:0] val_mem [arq_pkg::DEPTH];
  arq_pkg::row_t row_mem [arq_pkg::DEPTH];

  arq_pkg::entry_t cur;
  logic [arq_pkg::CNT_W-1:0] loaded;
  logic [arq_pkg::ENT_W-1:0] latest [arq_pkg::BITS];
  logic [arq_pkg::K_W-1:0] k;
  logic pend;
  arq_pkg::row_t acc;
  arq_pkg::row_t row_q;
  arq_pkg::row_t row_new;
  logic [arq_pkg::BITS-1:0] sv_q;
  logic [arq_pkg::IDX_W-1:0] row_addr;
  logic [arq_pkg::ENT_W-1:0] lat_k;
  logic [arq_pkg::ENT_W-1:0] lat_m1;
  logic row_rd;
  logic fire;
  logic hit;

  assign pop = (state == ST_IDLE) && !q_empty;
  assign lat_k = latest[k];
  assign lat_m1 = lat_k - 1'b1;
  assign fire = (state == ST_SCAN) && cur.value[k] && (lat_k != '0);
  assign row_rd = fire || (state == ST_QREAD);
  assign row_addr = (state == ST_QREAD) ? cur.t_pos[arq_pkg::IDX_W-1:0]
                                        : lat_m1[arq_pkg::IDX_W-1:0];

  always_comb begin
    for (int j = 0; j < arq_pkg::BITS; j++) begin
      row_new[j] = cur.value[j] ? latest[j] : acc[j];
    end
  end

  // Any start bit j whose latest chain start reaching t lies at or after s.
  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < arq_pkg::BITS; j++) begin
      if (sv_q[j] && (row_q[j] != '0) &&
          ({1'b0, cur.s_pos} + 1'b1 <= row_q[j])) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_entry.kind)
            arq_pkg::KIND_APPEND: state_next = ST_SCAN;
            arq_pkg::KIND_QUERY: state_next = ST_QREAD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: if (k == arq_pkg::K_W'(arq_pkg::BITS - 1)) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      ST_QREAD: state_next = ST_QEVAL;
      ST_QEVAL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (row_rd) row_q <= row_mem[row_addr];
    if (state == ST_QREAD) sv_q <= val_mem[cur.s_pos[arq_pkg::IDX_W-1:0]];
    if (state == ST_WRITE) begin
      row_mem[loaded[arq_pkg::IDX_W-1:0]] <= row_new;
      val_mem[loaded[arq_pkg::IDX_W-1:0]] <= cur.value;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_entry;
    if (state == ST_IDLE) begin
      acc <= '0;
    end else if (pend) begin
      for (int j = 0; j < arq_pkg::BITS; j++) begin
        if (row_q[j] > acc[j]) acc[j] <= row_q[j];
      end
    end
    rsp.reachable <= (state == ST_QEVAL) && hit && (cur.s_pos != cur.t_pos);
    rsp.bad_index <= pop && (q_entry.kind == arq_pkg::KIND_BAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      loaded <= '0;
      k <= '0;
      pend <= 1'b0;
      done <= 1'b0;
      for (int j = 0; j < arq_pkg::BITS; j++) latest[j] <= '0;
    end else begin
      state <= state_next;
      pend <= fire;
      done <= (state == ST_QEVAL) || (pop && (q_entry.kind == arq_pkg::KIND_BAD));
      if (state == ST_SCAN) k <= k + 1'b1;
      else k <= '0;
      if (state == ST_WRITE) begin
        loaded <= loaded + 1'b1;
        for (int j = 0; j < arq_pkg::BITS; j++) begin
          if (cur.value[j]) latest[j] <= loaded + 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/arq_checker.sv
// Port-level checks for the AND reachability query engine, bound to the top.
// Depends on arq_pkg and and_reachability_query_engine.
module arq_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input arq_pkg::rsp_t rsp
);

  // A position that is not loaded never reports reachability.
  a_bad_not_reach: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.reachable && rsp.bad_index))
    else $error("reachable set together with bad_index");

  // Reset empties the queue, so the engine takes items right after it.
  a_ready_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !busy)
    else $error("busy right after reset");

  // No result comes out of a reset cycle.
  a_quiet_after_rst: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

  // Right after reset the queue and the back are empty, so no result can
  // follow in the next cycle unless an item was taken.
  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    ($past(rst) && !start) |=> !done)
    else $error("result without any accepted item");

endmodule

bind and_reachability_query_engine arq_checker u_arq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

>>> tb/tb_and_reachability_query_engine.sv
// Self-checking testbench for the AND reachability query engine.
// Depends on arq_pkg and and_reachability_query_engine; results are checked
// against a behavioral predictor of the append and query rules, or a given result.
`timescale 1ns / 100ps

module tb_and_reachability_query_engine;

  localparam int RAND_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    arq_pkg::req_t item;
    bit has_rsp;
    arq_pkg::rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  arq_pkg::req_t req;
  logic done;
  arq_pkg::rsp_t rsp;

  // Predictor state, positions kept as index + 1 with 0 meaning none.
  logic [19:0] model_values [arq_pkg::DEPTH];
  logic [12:0] model_reach [arq_pkg::DEPTH][arq_pkg::BITS];
  logic [12:0] model_latest [arq_pkg::BITS];
  int model_count;

  arq_pkg::rsp_t pending_rsp_q[$];
  bit typed_valid_q[$];
  arq_pkg::rsp_t typed_rsp_q[$];
  int errors;
  int cycles;
  int issued_appends;

  and_reachability_query_engine i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void model_append(logic [19:0] v);
    logic [12:0] best;
    logic [12:0] p;
    int i;
    i = model_count;
    if (i >= arq_pkg::DEPTH) return;
    model_values[i] = v;
    for (int j = 0; j < arq_pkg::BITS; j++) begin
      best = '0;
      if (v[j]) begin
        best = model_latest[j];
      end else begin
        for (int k = 0; k < arq_pkg::BITS; k++) begin
          p = model_latest[k];
          if (v[k] && p != 0 && model_reach[p - 1][j] > best) best = model_reach[p - 1][j];
        end
      end
      model_reach[i][j] = best;
    end
    for (int j = 0; j < arq_pkg::BITS; j++)
      if (v[j]) model_latest[j] = 13'(i + 1);
    model_count = i + 1;
  endfunction

  function automatic arq_pkg::rsp_t model_query(int a, int b);
    arq_pkg::rsp_t r;
    int s;
    int t;
    r = '0;
    if (a >= model_count || b >= model_count) begin
      r.bad_index = 1'b1;
      return r;
    end
    s = (a < b) ? a : b;
    t = (a < b) ? b : a;
    if (s != t)
      for (int j = 0; j < arq_pkg::BITS; j++)
        if (model_values[s][j] && model_reach[t][j] != 0 && s + 1 <= model_reach[t][j])
          r.reachable = 1'b1;
    return r;
  endfunction

  // Accepted items feed the predictor; each result is held against the oldest one.
  always @(posedge clk) begin
    arq_pkg::rsp_t want;
    if (!rst) begin
      if (done) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected result, actual %b", $time, rsp);
          errors++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp.reachable !== want.reachable || rsp.bad_index !== want.bad_index) begin
            $display("%0t: mismatch, expected reachable=%b bad_index=%b, actual %b %b",
                     $time, want.reachable, want.bad_index, rsp.reachable, rsp.bad_index);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (req.req_type == arq_pkg::REQ_APPEND) begin
          model_append(req.value[arq_pkg::BITS-1:0]);
        end else begin
          want = model_query(int'(req.from_pos), int'(req.to_pos));
          if (typed_valid_q.size() != 0) begin
            if (typed_valid_q.pop_front()) want = typed_rsp_q.pop_front();
            else void'(typed_rsp_q.pop_front());
          end
          pending_rsp_q.push_back(want);
        end
      end
    end
  end

  task automatic send_item(arq_pkg::req_t item);
    start <= 1'b1;
    req <= item;
    if (item.req_type == arq_pkg::REQ_APPEND) issued_appends++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic arq_pkg::req_t make_append(logic [19:0] v);
    arq_pkg::req_t r;
    r = '0;
    r.req_type = arq_pkg::REQ_APPEND;
    r.value = v;
    return r;
  endfunction

  function automatic arq_pkg::req_t make_query(int a, int b);
    arq_pkg::req_t r;
    r = '0;
    r.req_type = arq_pkg::REQ_QUERY;
    r.value = 20'($urandom);
    r.from_pos = arq_pkg::POS_W'(a);
    r.to_pos = arq_pkg::POS_W'(b);
    return r;
  endfunction

  // Sparse values build long chains; a few are zero or dense.
  function automatic logic [19:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2, 3: return 20'(1) << $urandom_range(0, 19);
      4, 5: return (20'(1) << $urandom_range(0, 19)) | (20'(1) << $urandom_range(0, 19));
      6, 7: return 20'($urandom & $urandom & $urandom);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic arq_pkg::req_t pick_query();
    int loaded;
    int t;
    loaded = (issued_appends < arq_pkg::DEPTH) ? issued_appends : arq_pkg::DEPTH;
    if (loaded == 0 || $urandom_range(0, 99) < 12)
      return make_query($urandom_range(0, 4095), $urandom_range(0, 4095));
    t = $urandom_range(0, loaded - 1);
    if ($urandom_range(0, 1) != 0)
      return make_query(t, $urandom_range(0, loaded - 1));
    return make_query(t, (t > 30) ? t - $urandom_range(0, 30) : $urandom_range(0, t));
  endfunction

  task automatic send_random(arq_pkg::req_t item, ref int burst_left);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
      burst_left = $urandom_range(1, 20);
    end
    send_item(item);
    burst_left--;
  endtask

  task automatic wait_drained();
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    dir_row_t rows[$];
    arq_pkg::rsp_t none_rsp;
    arq_pkg::rsp_t bad_rsp;
    int burst_left;
    none_rsp = '0;
    bad_rsp = '0;
    bad_rsp.bad_index = 1'b1;
    errors = 0;
    cycles = 0;
    issued_appends = 0;
    burst_left = 0;
    model_count = 0;
    foreach (model_latest[j]) model_latest[j] = '0;
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;

    rows.push_back('{make_query(0, 0), 1'b1, bad_rsp});
    rows.push_back('{make_append(20'h00000), 1'b0, none_rsp});
    rows.push_back('{make_append(20'hFFFFF), 1'b0, none_rsp});
    rows.push_back('{make_append(20'h00001), 1'b0, none_rsp});
    rows.push_back('{make_append(20'h00003), 1'b0, none_rsp});
    rows.push_back('{make_append(20'h80000), 1'b0, none_rsp});
    rows.push_back('{make_append(20'h80002), 1'b0, none_rsp});
    rows.push_back('{make_query(0, 1), 1'b1, none_rsp});
    rows.push_back('{make_query(2, 2), 1'b1, none_rsp});
    rows.push_back('{make_query(1, 6), 1'b1, bad_rsp});
    rows.push_back('{make_query(4095, 0), 1'b1, bad_rsp});
    rows.push_back('{make_query(0, 4095), 1'b1, bad_rsp});
    rows.push_back('{make_query(1, 3), 1'b0, none_rsp});
    rows.push_back('{make_query(3, 1), 1'b0, none_rsp});
    rows.push_back('{make_query(2, 5), 1'b0, none_rsp});
    rows.push_back('{make_query(3, 5), 1'b0, none_rsp});
    rows.push_back('{make_query(5, 1), 1'b0, none_rsp});
    rows.push_back('{make_query(4, 5), 1'b0, none_rsp});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[n]) begin
      if (rows[n].item.req_type == arq_pkg::REQ_QUERY) begin
        typed_valid_q.push_back(rows[n].has_rsp);
        typed_rsp_q.push_back(rows[n].rsp);
      end
      send_item(rows[n].item);
    end
    idle_cycles(0);
    wait_drained();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        idle_cycles(0);
        wait_drained();
      end
      send_random(($urandom_range(0, 1) != 0) ? make_append(pick_value()) : pick_query(),
                  burst_left);
    end

    for (int n = 0; n < 60; n++) send_random(pick_query(), burst_left);
    send_item(make_query(4095, 0));
    send_item(make_query(4095, 4094));
    idle_cycles(0);

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
